// ----- rtl/elfr_pkg.sv -----
// ============================================================================
// elfr_pkg: shared types and constants
// Byte codes, field widths and parse phase encoding for the escaped
// length frame receiver.
// ============================================================================
package elfr_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;

    localparam logic [BYTE_W-1:0] START_BYTE  = 8'h7E;
    localparam logic [BYTE_W-1:0] ESCAPE_BYTE = 8'h7D;
    localparam logic [BYTE_W-1:0] ESCAPE_XOR  = 8'h20;
    localparam logic [BYTE_W-1:0] GOOD_SUM    = 8'hFF;

    // Parse phases; PH_EMIT is the readout burst of a validated frame
    typedef enum logic [2:0] {
        PH_WAIT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_DATA,
        PH_CHECK,
        PH_EMIT
    } phase_t;

endpackage

// ----- rtl/elfr_if.sv -----
// ============================================================================
// elfr_if: channel interfaces
// Valid/ready channels for received bytes and for validated payload items.
// ============================================================================
interface elfr_in_if
    import elfr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface elfr_out_if
    import elfr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] payload_byte;
    logic              last_byte;
    logic [LEN_W-1:0]  frame_length;
    logic              empty_frame;

    modport source (output valid, output payload_byte, output last_byte,
                    output frame_length, output empty_frame, input ready);
    modport sink   (input valid, input payload_byte, input last_byte,
                    input frame_length, input empty_frame, output ready);
endinterface

// ----- rtl/escaped_length_frame_receiver.sv -----
// ============================================================================
// escaped_length_frame_receiver: escaped, length-prefixed frame receiver
// Parses start/length/payload/checksum frames, stores the payload in a
// local memory and plays it back once the checksum passes.
// ============================================================================
// Takes one received byte per cycle while parsing. A raw 0x7E always restarts
// a frame; 0x7D escapes the next byte (XOR 0x20). Payload bytes go into a
// MAX_PAYLOAD x 8 memory with a registered read. When the checksum passes,
// input stalls (rx.ready low) and the frame is read back: each payload item
// is read from memory, then loaded into the output register. Input stays held
// until the last item is loaded, later under output backpressure; an empty
// frame gives one marker item. A failed checksum gives no items and no stall.
// No clearing pass after reset: every entry read back was written in the same
// frame.
module escaped_length_frame_receiver
    import elfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    elfr_in_if.sink           rx,
    elfr_out_if.source        frame
);

    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    // Parse state
    phase_t            phase_reg, phase_next;
    logic              esc_reg, esc_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [LEN_W-1:0]  exp_len_reg, exp_len_next;
    logic [LEN_W-1:0]  stored_reg, stored_next;

    // Readout control
    logic [LEN_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              rd_pend_reg, rd_pend_next;
    logic              rd_last_reg, rd_last_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;
    logic              out_empty_reg, out_empty_next;

    // Payload memory
    logic [BYTE_W-1:0] mem [MAX_PAYLOAD];
    logic [BYTE_W-1:0] mem_q_reg;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [BYTE_W-1:0] mem_wdata;

    logic              in_acc;
    logic              out_free;
    logic [BYTE_W-1:0] dec_byte;
    logic [BYTE_W-1:0] sum_add;
    logic [LEN_W-1:0]  stored_inc;
    logic [LEN_W-1:0]  rd_idx_inc;

    assign rx.ready     = (phase_reg != PH_EMIT);
    assign in_acc       = rx.valid && rx.ready;
    assign out_free     = !out_valid_reg || frame.ready;
    assign dec_byte     = esc_reg ? (rx.rx_byte ^ ESCAPE_XOR) : rx.rx_byte;
    assign sum_add      = sum_reg + dec_byte;
    assign stored_inc   = stored_reg + LEN_W'(1);
    assign rd_idx_inc   = rd_idx_reg + LEN_W'(1);

    assign frame.valid        = out_valid_reg;
    assign frame.payload_byte = out_byte_reg;
    assign frame.last_byte    = out_last_reg;
    assign frame.frame_length = out_len_reg;
    assign frame.empty_frame  = out_empty_reg;

    // Next state: parsing and readout sequencing
    always_comb
    begin
        phase_next     = phase_reg;
        esc_next       = esc_reg;
        sum_next       = sum_reg;
        exp_len_next   = exp_len_reg;
        stored_next    = stored_reg;
        rd_idx_next    = rd_idx_reg;
        rd_pend_next   = 1'b0;
        rd_last_next   = rd_last_reg;
        out_valid_next = out_valid_reg && !frame.ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_len_next   = out_len_reg;
        out_empty_next = out_empty_reg;
        mem_we         = 1'b0;
        mem_waddr      = stored_reg[ADDR_W-1:0];
        mem_wdata      = dec_byte;
        mem_re         = 1'b0;
        mem_raddr      = rd_idx_reg[ADDR_W-1:0];

        if (phase_reg == PH_EMIT)
        begin
            if (exp_len_reg == '0)
            begin
                // empty frame marker
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = '0;
                    out_last_next  = 1'b1;
                    out_len_next   = '0;
                    out_empty_next = 1'b1;
                    phase_next     = PH_WAIT;
                end
            end
            else
            begin
                // read data lands in the output register
                if (rd_pend_reg)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = mem_q_reg;
                    out_last_next  = rd_last_reg;
                    out_len_next   = exp_len_reg;
                    out_empty_next = 1'b0;
                    if (rd_last_reg)
                    begin
                        phase_next = PH_WAIT;
                    end
                end
                else if (out_free)
                begin
                    // slot is free by the time the data returns
                    mem_re       = 1'b1;
                    rd_pend_next = 1'b1;
                    rd_last_next = (rd_idx_inc == exp_len_reg);
                    rd_idx_next  = rd_idx_inc;
                end
            end
        end
        else if (in_acc)
        begin
            if (rx.rx_byte == START_BYTE)
            begin
                esc_next    = 1'b0;
                stored_next = '0;
                sum_next    = '0;
                phase_next  = PH_LEN_HI;
            end
            else if (!esc_reg && rx.rx_byte == ESCAPE_BYTE)
            begin
                esc_next = 1'b1;
            end
            else
            begin
                esc_next = 1'b0;
                unique case (phase_reg)
                    PH_LEN_HI:
                    begin
                        phase_next = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        if (dec_byte <= BYTE_W'(MAX_PAYLOAD))
                        begin
                            exp_len_next = dec_byte[LEN_W-1:0];
                            phase_next   = (dec_byte == '0) ? PH_CHECK : PH_DATA;
                        end
                        else
                        begin
                            exp_len_next = '0;
                            phase_next   = PH_WAIT;
                        end
                    end
                    PH_DATA:
                    begin
                        sum_next    = sum_add;
                        mem_we      = 1'b1;
                        stored_next = stored_inc;
                        if (stored_inc >= exp_len_reg)
                        begin
                            phase_next = PH_CHECK;
                        end
                    end
                    PH_CHECK:
                    begin
                        sum_next    = sum_add;
                        rd_idx_next = '0;
                        phase_next  = (sum_add == GOOD_SUM) ? PH_EMIT : PH_WAIT;
                    end
                    default:
                    begin
                        phase_next = PH_WAIT;
                    end
                endcase
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            esc_reg       <= 1'b0;
            sum_reg       <= '0;
            exp_len_reg   <= '0;
            stored_reg    <= '0;
            rd_idx_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            rd_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            esc_reg       <= esc_next;
            sum_reg       <= sum_next;
            exp_len_reg   <= exp_len_next;
            stored_reg    <= stored_next;
            rd_idx_reg    <= rd_idx_next;
            rd_pend_reg   <= rd_pend_next;
            rd_last_reg   <= rd_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload registers
    always_ff @(posedge clk)
    begin
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_len_reg   <= out_len_next;
        out_empty_reg <= out_empty_next;
    end

    // Payload memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q_reg <= mem[mem_raddr];
        end
    end

    // Read data never arrives on top of an unconsumed item
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> !out_valid_reg)
        else $error("read data arrived while output register busy");

    // Reads are only in flight during readout
    a_pend_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (phase_reg == PH_EMIT))
        else $error("memory read outside readout");

    // Store count stays below the frame length while collecting payload
    a_stored_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (stored_reg < exp_len_reg))
        else $error("payload count overran frame length");

    // Empty-frame marker is a single last item with zero length
    a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_empty_reg) |-> (out_last_reg && out_len_reg == '0))
        else $error("malformed empty-frame marker");

endmodule

// ----- bench/elfr_frame_checker.sv -----
// ============================================================================
// elfr_frame_checker: payload predictor and scoreboard
// Watches the received-byte channel and the payload channel of the escaped
// length frame receiver. Every accepted byte runs through a local frame
// parser, which queues the payload items a validated frame must produce.
// Each accepted payload item is checked field by field against the oldest
// queued one. Mismatches and unexpected items bump the failure count.
// ============================================================================
module elfr_frame_checker
    import elfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic clk,
    input  logic rst_n,
    elfr_in_if   rx,
    elfr_out_if  frame,
    output int   fail_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              last_byte;
        logic [LEN_W-1:0]  frame_length;
        logic              empty_frame;
    } payload_item_t;

    // Parser state of the predicted block
    phase_t            phase;
    logic              esc_pending;
    logic [BYTE_W-1:0] frame_sum;
    logic [LEN_W-1:0]  want_length;
    logic [LEN_W-1:0]  stored_count;
    logic [BYTE_W-1:0] payload_mem [MAX_PAYLOAD];

    payload_item_t     expected_items [$];

    // Advance the parser by one raw byte; queue the items of a good frame
    task automatic absorb_rx_byte(input logic [BYTE_W-1:0] raw);
        logic [BYTE_W-1:0] b;
        payload_item_t     item;
        int                k;
        b = raw;
        if (raw == START_BYTE) begin
            esc_pending  = 1'b0;
            stored_count = '0;
            frame_sum    = '0;
            phase        = PH_LEN_HI;
            return;
        end
        if (esc_pending) begin
            esc_pending = 1'b0;
            b = b ^ ESCAPE_XOR;
        end else if (raw == ESCAPE_BYTE) begin
            esc_pending = 1'b1;
            return;
        end
        case (phase)
            PH_LEN_HI: phase = PH_LEN_LO;
            PH_LEN_LO:
            begin
                if (b <= MAX_PAYLOAD) begin
                    want_length = b[LEN_W-1:0];
                    phase = (b == 0) ? PH_CHECK : PH_DATA;
                end else begin
                    want_length = '0;
                    phase = PH_WAIT;
                end
            end
            PH_DATA:
            begin
                frame_sum = frame_sum + b;
                if (stored_count < MAX_PAYLOAD)
                    payload_mem[stored_count] = b;
                stored_count = stored_count + 1'b1;
                if (stored_count >= want_length)
                    phase = PH_CHECK;
            end
            PH_CHECK:
            begin
                frame_sum = frame_sum + b;
                phase = PH_WAIT;
                if (frame_sum == GOOD_SUM) begin
                    if (want_length == 0) begin
                        // empty frame: a single marker item
                        item.payload_byte = '0;
                        item.last_byte    = 1'b1;
                        item.frame_length = '0;
                        item.empty_frame  = 1'b1;
                        expected_items.push_back(item);
                    end else begin
                        for (k = 0; k < want_length; k++) begin
                            item.payload_byte = payload_mem[k];
                            item.last_byte    = (k + 1 == want_length);
                            item.frame_length = want_length;
                            item.empty_frame  = 1'b0;
                            expected_items.push_back(item);
                        end
                    end
                end
            end
            default: phase = PH_WAIT;
        endcase
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Sample both channels at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        payload_item_t want;
        if (!rst_n) begin
            phase        = PH_WAIT;
            esc_pending  = 1'b0;
            frame_sum    = '0;
            want_length  = '0;
            stored_count = '0;
            fail_count   = 0;
            expected_items.delete();
        end else begin
            if (rx.valid && rx.ready)
                absorb_rx_byte(rx.rx_byte);
            if (frame.valid && frame.ready) begin
                if (expected_items.size() == 0) begin
                    $error("payload item with nothing expected: byte %0d last %0d",
                           frame.payload_byte, frame.last_byte);
                    fail_count++;
                end else begin
                    want = expected_items.pop_front();
                    check_field("payload_byte", want.payload_byte, frame.payload_byte);
                    check_field("last_byte", want.last_byte, frame.last_byte);
                    check_field("frame_length", want.frame_length, frame.frame_length);
                    check_field("empty_frame", want.empty_frame, frame.empty_frame);
                end
            end
        end
        pending = expected_items.size();
    end

endmodule

// ----- bench/escaped_length_frame_receiver_test.sv -----
// ============================================================================
// escaped_length_frame_receiver_test: testbench top
// Drives escaped, length-prefixed frames into the receiver: a directed set of
// corner frames, then random good, corrupted, truncated and oversized frames
// mixed with line noise. Both channels idle at random, and the payload side
// holds off once for a long stretch so the block backs up its input.
// ============================================================================
module escaped_length_frame_receiver_test;
    timeunit 1ns;
    timeprecision 1ps;

    import elfr_pkg::*;

    localparam int MAX_PAYLOAD  = 64;
    localparam int ITEM_TARGET  = 220;
    localparam int HOLD_CYCLES  = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int LIMIT_CYCLES = 200000;

    // Corner frames: escape outside a frame, oversized length, empty frame,
    // single 0xFF byte, escaped start value as data, raw start after escape
    localparam logic [BYTE_W-1:0] DIRECTED_BYTES [27] = '{
        ESCAPE_BYTE, 8'h41,
        START_BYTE, 8'h00, 8'hFF,
        START_BYTE, 8'h00, 8'h00, 8'hFF,
        START_BYTE, 8'h00, 8'h01, 8'hFF, 8'h00,
        START_BYTE, 8'h00, 8'h02, 8'h00, ESCAPE_BYTE, 8'h5E, 8'h81,
        START_BYTE, ESCAPE_BYTE, START_BYTE, 8'h00, 8'h00, 8'hFF
    };

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count;
    int   counted_bytes;
    int   calm_left;
    bit   hold_off_req;

    elfr_in_if  rx_ch ();
    elfr_out_if frame_ch ();

    escaped_length_frame_receiver #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .frame (frame_ch)
    );

    elfr_frame_checker #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) frame_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx_ch),
        .frame      (frame_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Watchdog
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offer one raw byte after a random gap and wait until it is taken
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        int pick;
        gap = 0;
        if (calm_left > 0)
            calm_left--;
        else if ($urandom_range(0, 19) == 0)
            calm_left = $urandom_range(10, 40);
        else begin
            pick = $urandom_range(0, 99);
            if (pick >= 50)
                gap = (pick < 90) ? $urandom_range(1, 3) : $urandom_range(4, 25);
        end
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready) @(posedge clk);
        counted_bytes++;
    endtask

    // Escape a decoded byte when needed, and now and then when not
    task automatic send_coded(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] flipped;
        flipped = b ^ ESCAPE_XOR;
        if (b == START_BYTE || b == ESCAPE_BYTE
            || (flipped != START_BYTE && $urandom_range(0, 15) == 0)) begin
            send_byte(ESCAPE_BYTE);
            send_byte(flipped);
        end else begin
            send_byte(b);
        end
    endtask

    // One frame; cut >= 0 stops after that payload byte, good = 0 spoils the sum
    task automatic send_frame(input int len, input int cut, input bit good);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        int                i;
        send_byte(START_BYTE);
        send_coded(BYTE_W'($urandom_range(0, 255)));
        send_coded(len[BYTE_W-1:0]);
        if (len > MAX_PAYLOAD) begin
            repeat ($urandom_range(0, 3)) send_byte(BYTE_W'($urandom_range(0, 255)));
            return;
        end
        sum = '0;
        for (i = 0; i < len; i++) begin
            case ($urandom_range(0, 7))
                0:       b = START_BYTE;
                1:       b = ESCAPE_BYTE;
                default: b = BYTE_W'($urandom_range(0, 255));
            endcase
            sum = sum + b;
            send_coded(b);
            if (i == cut)
                return;
        end
        b = GOOD_SUM - sum;
        if (!good)
            b = b ^ BYTE_W'($urandom_range(1, 255));
        send_coded(b);
    endtask

    // Payload side: random ready stretches, plus the requested long hold-off
    initial
    begin
        int mode;
        int span;
        bit held;
        held = 1'b0;
        frame_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_off_req && !held) begin
                frame_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                held = 1'b1;
            end else begin
                mode = $urandom_range(0, 99);
                span = $urandom_range(1, 20);
                if (mode < 35) begin
                    frame_ch.ready <= 1'b1;
                    repeat (span) @(posedge clk);
                end else if (mode < 85) begin
                    repeat (span) begin
                        frame_ch.ready <= ($urandom_range(0, 3) != 0);
                        @(posedge clk);
                    end
                end else begin
                    frame_ch.ready <= 1'b0;
                    repeat ($urandom_range(5, 30)) @(posedge clk);
                end
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        int kind;
        int len;
        int n;
        rst_n         = 1'b0;
        counted_bytes = 0;
        calm_left     = 0;
        hold_off_req  = 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_BYTES[i])
            send_byte(DIRECTED_BYTES[i]);

        // Full-size frame while the payload side is held off
        hold_off_req = 1'b1;
        send_frame(MAX_PAYLOAD, -1, 1'b1);

        while (counted_bytes < ITEM_TARGET) begin
            kind = $urandom_range(0, 99);
            if ($urandom_range(0, 24) == 0)
                len = MAX_PAYLOAD;
            else if ($urandom_range(0, 9) == 0)
                len = $urandom_range(9, MAX_PAYLOAD - 1);
            else
                len = $urandom_range(0, 8);
            // keep the total byte count near the target
            if (len > ITEM_TARGET - counted_bytes)
                len = $urandom_range(0, 8);
            if (kind < 70)
                send_frame(len, -1, 1'b1);
            else if (kind < 78)
                send_frame(len, -1, 1'b0);
            else if (kind < 86) begin
                if (len == 0)
                    len = 1;
                send_frame(len, $urandom_range(0, len - 1), 1'b1);
            end else if (kind < 93)
                send_frame($urandom_range(MAX_PAYLOAD + 1, 255), -1, 1'b1);
            else begin
                // line noise, partly stray escapes
                n = $urandom_range(1, 4);
                repeat (n)
                    send_byte(($urandom_range(0, 3) == 0) ? ESCAPE_BYTE
                                                          : BYTE_W'($urandom_range(0, 255)));
            end
        end
        rx_ch.valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
